// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of i_clk, switched off while reset is held.
`define CLO_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("closed loop orderer check failed");

// Checked at every rising edge, reset cycles included.
`define CLO_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("closed loop orderer reset check failed");

`endif

// ===== rtl/core/clo_pkg.sv =====
package clo_pkg;

    localparam int MAX_LINES_DEF = 32;
    localparam int COORD_W       = 24;
    localparam int ID_W          = 16;
    localparam int STATUS_W      = 4;
    localparam int POS_W         = 5;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int PROD_W        = 2 * DIFF_W;
    localparam int ORIENT_W      = PROD_W + 1;
    localparam int BOX_W         = COORD_W + 2;
    localparam int PTOL_W        = 8;
    localparam int ATOL_W        = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_TOL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_TOL  = 1'd1;

    localparam logic [STATUS_W-1:0] STS_OK       = 4'd0;
    localparam logic [STATUS_W-1:0] STS_TOO_FEW  = 4'd1;
    localparam logic [STATUS_W-1:0] STS_DUP      = 4'd2;
    localparam logic [STATUS_W-1:0] STS_DEGEN    = 4'd3;
    localparam logic [STATUS_W-1:0] STS_CONTOUR  = 4'd4;
    localparam logic [STATUS_W-1:0] STS_BRANCH   = 4'd5;
    localparam logic [STATUS_W-1:0] STS_WALK_GAP = 4'd6;
    localparam logic [STATUS_W-1:0] STS_AMBIG    = 4'd7;
    localparam logic [STATUS_W-1:0] STS_OPEN     = 4'd8;
    localparam logic [STATUS_W-1:0] STS_SELF_X   = 4'd9;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW = 4'd10;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_pt;

    typedef struct packed {
        logic [ID_W-1:0] id;
        t_pt             s;
        t_pt             e;
    } t_edge;

    typedef struct packed {
        logic [ID_W-1:0]           segment_id;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic                      last_segment;
    } t_seg_in;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [POS_W-1:0]          position;
        logic [ID_W-1:0]           edge_id;
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic                      last_result;
    } t_result;

    typedef struct packed {
        logic start;
        t_pt  a;
        t_pt  b;
        t_pt  c;
    } t_orient_req;

    typedef struct packed {
        logic                       done;
        logic signed [ORIENT_W-1:0] o;
    } t_orient_rsp;

    typedef enum logic [4:0] {
        ST_IDLE, ST_EVAL, ST_DUP_RD, ST_DUP_EX, ST_PA_RD, ST_PA_SEL, ST_PF_RD,
        ST_PF_EX, ST_PF_NEW, ST_DG_RD, ST_DG_EX, ST_PT_DONE, ST_DS_RD, ST_DS_EX,
        ST_W0_RD, ST_W0_EX, ST_WS_RD, ST_WS_EX, ST_WC, ST_CLOSE, ST_X_RD,
        ST_X_EX, ST_XO, ST_XW, ST_X_EV, ST_O_RD, ST_O_EX, ST_O_WAIT
    } t_state;

    typedef enum logic [2:0] {
        OPH_IDLE, OPH_MUL1, OPH_MUL2, OPH_SUB, OPH_DONE
    } t_oph;

    function automatic logic same_pt(t_pt a, t_pt b, logic [PTOL_W-1:0] tol);
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [DIFF_W-1:0]        ax;
        logic [DIFF_W-1:0]        ay;
        dx = DIFF_W'(a.x) - DIFF_W'(b.x);
        dy = DIFF_W'(a.y) - DIFF_W'(b.y);
        ax = dx[DIFF_W-1] ? -dx : dx;
        ay = dy[DIFF_W-1] ? -dy : dy;
        return (ax <= DIFF_W'(tol)) && (ay <= DIFF_W'(tol));
    endfunction

    function automatic logic in_box(t_pt a, t_pt b, t_pt p, logic [PTOL_W-1:0] tol);
        logic signed [BOX_W-1:0] t;
        logic signed [BOX_W-1:0] lo_x;
        logic signed [BOX_W-1:0] hi_x;
        logic signed [BOX_W-1:0] lo_y;
        logic signed [BOX_W-1:0] hi_y;
        t    = $signed(BOX_W'(tol));
        lo_x = ((a.x < b.x) ? BOX_W'(a.x) : BOX_W'(b.x)) - t;
        hi_x = ((a.x > b.x) ? BOX_W'(a.x) : BOX_W'(b.x)) + t;
        lo_y = ((a.y < b.y) ? BOX_W'(a.y) : BOX_W'(b.y)) - t;
        hi_y = ((a.y > b.y) ? BOX_W'(a.y) : BOX_W'(b.y)) + t;
        return (lo_x <= BOX_W'(p.x)) && (BOX_W'(p.x) <= hi_x) &&
               (lo_y <= BOX_W'(p.y)) && (BOX_W'(p.y) <= hi_y);
    endfunction

    function automatic logic is_pos(logic signed [ORIENT_W-1:0] o, logic [ATOL_W-1:0] tol);
        return o > $signed(ORIENT_W'(tol));
    endfunction

    function automatic logic is_neg(logic signed [ORIENT_W-1:0] o, logic [ATOL_W-1:0] tol);
        return o < -$signed(ORIENT_W'(tol));
    endfunction

    // Proper crossing, or a collinear endpoint lying on the other edge.
    function automatic logic crosses(logic signed [ORIENT_W-1:0] o1,
                                     logic signed [ORIENT_W-1:0] o2,
                                     logic signed [ORIENT_W-1:0] o3,
                                     logic signed [ORIENT_W-1:0] o4,
                                     t_edge a, t_edge b,
                                     logic [PTOL_W-1:0] ptol,
                                     logic [ATOL_W-1:0] atol);
        logic prop;
        logic touch;
        prop  = ((is_pos(o1, atol) && is_neg(o2, atol)) ||
                 (is_neg(o1, atol) && is_pos(o2, atol))) &&
                ((is_pos(o3, atol) && is_neg(o4, atol)) ||
                 (is_neg(o3, atol) && is_pos(o4, atol)));
        touch = (!is_pos(o1, atol) && !is_neg(o1, atol) && in_box(a.s, a.e, b.s, ptol)) ||
                (!is_pos(o2, atol) && !is_neg(o2, atol) && in_box(a.s, a.e, b.e, ptol)) ||
                (!is_pos(o3, atol) && !is_neg(o3, atol) && in_box(b.s, b.e, a.s, ptol)) ||
                (!is_pos(o4, atol) && !is_neg(o4, atol) && in_box(b.s, b.e, a.e, ptol));
        return prop || touch;
    endfunction

    function automatic t_result err_result(logic [STATUS_W-1:0] code);
        t_result r;
        r             = '0;
        r.status      = code;
        r.last_result = 1'b1;
        return r;
    endfunction

endpackage

// ===== rtl/core/clo_stream_if.sv =====
interface clo_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/clo_orient.sv =====
module clo_orient
    import clo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_orient_req i_req,
    output t_orient_rsp o_rsp
);

    t_oph r_ph, n_ph;

    logic signed [DIFF_W-1:0]   r_dx1, r_dy2, r_dy1, r_dx2;
    logic signed [PROD_W-1:0]   r_m1, r_m2;
    logic signed [ORIENT_W-1:0] r_o;
    logic signed [DIFF_W-1:0]   op_a, op_b;
    logic signed [PROD_W-1:0]   prod;

    always_comb begin
        n_ph = r_ph;
        case (r_ph)
            OPH_IDLE: if (i_req.start) n_ph = OPH_MUL1;
            OPH_MUL1: n_ph = OPH_MUL2;
            OPH_MUL2: n_ph = OPH_SUB;
            OPH_SUB:  n_ph = OPH_DONE;
            OPH_DONE: n_ph = OPH_IDLE;
            default:  n_ph = OPH_IDLE;
        endcase
    end

    // One multiplier serves both products of the cross product.
    always_comb begin
        case (r_ph)
            OPH_MUL1: begin
                op_a = r_dx1;
                op_b = r_dy2;
            end
            default: begin
                op_a = r_dy1;
                op_b = r_dx2;
            end
        endcase
        prod       = op_a * op_b;
        o_rsp.done = (r_ph == OPH_DONE);
        o_rsp.o    = r_o;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= OPH_IDLE;
        end else begin
            r_ph <= n_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ph == OPH_IDLE && i_req.start) begin
            r_dx1 <= DIFF_W'(i_req.b.x) - DIFF_W'(i_req.a.x);
            r_dy2 <= DIFF_W'(i_req.c.y) - DIFF_W'(i_req.a.y);
            r_dy1 <= DIFF_W'(i_req.b.y) - DIFF_W'(i_req.a.y);
            r_dx2 <= DIFF_W'(i_req.c.x) - DIFF_W'(i_req.a.x);
        end
        if (r_ph == OPH_MUL1) r_m1 <= prod;
        if (r_ph == OPH_MUL2) r_m2 <= prod;
        if (r_ph == OPH_SUB)  r_o  <= ORIENT_W'(r_m1) - ORIENT_W'(r_m2);
    end

endmodule

// ===== rtl/core/closed_loop_orderer.sv =====
// Operation: a segment request is taken while the block is idle; the request marked last
// starts an evaluation that checks every segment pair, looks up each endpoint among the
// stored points, checks edge counts, walks the loop and tests each edge pair before any result.
// Flow: one set at a time; results then leave one by one, each held until o_res is ready.
// The memory reads and the one cross-product multiplier, shared by both products, set the pace.
// Reset: synchronous, active low; empties the set and clears both tolerance registers.
module closed_loop_orderer
    import clo_pkg::*;
#(
    parameter int MAX_LINES = MAX_LINES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    clo_stream_if.sink            i_seg,
    clo_stream_if.source          o_res
);

    // Index, count and point-table widths follow the set size.
    localparam int IW    = $clog2(MAX_LINES);
    localparam int CW    = $clog2(MAX_LINES + 1);
    localparam int PTS_N = 2 * MAX_LINES;
    localparam int PW    = $clog2(PTS_N);
    localparam int PCW   = $clog2(PTS_N + 1);

    // Stored segments, the edges in loop order (oriented), and the table of distinct
    // points with a saturating edge count per point. Only filled entries are used.
    t_edge      seg_mem  [MAX_LINES];
    t_edge      loop_mem [MAX_LINES];
    t_pt        pts_mem  [PTS_N];
    logic [1:0] deg_mem  [PTS_N];

    t_edge      r_sa, r_sb, r_la, r_lb;
    t_pt        r_pd;
    logic [1:0] r_dd;

    t_state r_state, n_state;

    logic [PTOL_W-1:0]   r_ptol;
    logic [ATOL_W-1:0]   r_atol;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_ovf, n_ovf;
    logic [IW-1:0]       r_i, n_i, r_j, n_j, r_k, n_k, r_pick_i, n_pick_i;
    logic [PCW-1:0]      r_np, n_np;
    logic [PW-1:0]       r_pk, n_pk, r_idx, n_idx, r_sidx, n_sidx;
    logic                r_half, n_half;
    t_pt                 r_p, n_p, r_start, n_start, r_cur, n_cur;
    logic [MAX_LINES-1:0] r_used, n_used;
    logic                r_found, n_found;
    t_edge               r_pick, n_pick;
    logic [1:0]          r_m, n_m;
    logic signed [ORIENT_W-1:0] r_ox [4];
    logic signed [ORIENT_W-1:0] n_ox [4];
    t_result             r_out, n_out;
    logic                r_ov, n_ov;

    logic        seg_we, loop_we, pts_we, deg_we;
    t_edge       seg_wdata, loop_wdata;
    logic [IW-1:0] loop_waddr;
    logic [PW-1:0] pts_waddr;
    logic [1:0]  deg_wdata;
    t_orient_req orq;
    t_orient_rsp ors;

    logic acc_in, last_i, last_j, k_last, i2_end, pk_last, x_done, x_skip;
    logic dup_hit, pf_hit, w_ms, w_me, w_hit, close_ok, x_cross;

    clo_orient u_orient (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (orq),
        .o_rsp   (ors)
    );

    assign i_seg.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;
    assign acc_in      = i_seg.valid && (r_state == ST_IDLE);

    assign seg_wdata.id  = i_seg.data.segment_id;
    assign seg_wdata.s.x = i_seg.data.start_x;
    assign seg_wdata.s.y = i_seg.data.start_y;
    assign seg_wdata.e.x = i_seg.data.end_x;
    assign seg_wdata.e.y = i_seg.data.end_y;

    // Loop-bound and comparison flags shared by the sequencer blocks.
    assign last_i  = (CW'(r_i) + CW'(1)) == r_cnt;
    assign last_j  = (CW'(r_j) + CW'(1)) == r_cnt;
    assign k_last  = (CW'(r_k) + CW'(1)) == r_cnt;
    assign i2_end  = (CW'(r_i) + CW'(2)) == r_cnt;
    assign pk_last = (PCW'(r_pk) + PCW'(1)) == r_np;
    assign x_done  = last_j && i2_end;
    assign x_skip  = ((CW'(r_j)) == (CW'(r_i) + CW'(1))) || ((r_i == '0) && last_j);

    assign dup_hit  = (r_sa.id == r_sb.id) ||
                      (same_pt(r_sa.s, r_sb.s, r_ptol) && same_pt(r_sa.e, r_sb.e, r_ptol)) ||
                      (same_pt(r_sa.s, r_sb.e, r_ptol) && same_pt(r_sa.e, r_sb.s, r_ptol));
    assign pf_hit   = same_pt(r_pd, r_p, r_ptol);
    assign w_ms     = same_pt(r_sa.s, r_cur, r_ptol);
    assign w_me     = same_pt(r_sa.e, r_cur, r_ptol);
    assign w_hit    = !r_used[r_i] && (w_ms || w_me);
    assign close_ok = same_pt(r_cur, r_start, r_ptol);
    assign x_cross  = crosses(r_ox[0], r_ox[1], r_ox[2], r_ox[3], r_la, r_lb, r_ptol, r_atol);

    // Operands of the orientation unit for the four tests of one edge pair.
    always_comb begin
        orq.start = (r_state == ST_XO);
        case (r_m)
            2'd0: begin
                orq.a = r_la.s;
                orq.b = r_la.e;
                orq.c = r_lb.s;
            end
            2'd1: begin
                orq.a = r_la.s;
                orq.b = r_la.e;
                orq.c = r_lb.e;
            end
            2'd2: begin
                orq.a = r_lb.s;
                orq.b = r_lb.e;
                orq.c = r_la.s;
            end
            default: begin
                orq.a = r_lb.s;
                orq.b = r_lb.e;
                orq.c = r_la.e;
            end
        endcase
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (acc_in && i_seg.data.last_segment) n_state = ST_EVAL;
            ST_EVAL:    n_state = (r_ovf || r_cnt < CW'(3)) ? ST_O_WAIT : ST_DUP_RD;
            ST_DUP_RD:  n_state = ST_DUP_EX;
            ST_DUP_EX: begin
                if (dup_hit) n_state = ST_O_WAIT;
                else if (x_done) n_state = ST_PA_RD;
                else n_state = ST_DUP_RD;
            end
            ST_PA_RD:   n_state = ST_PA_SEL;
            ST_PA_SEL:  n_state = (r_np == '0) ? ST_PF_NEW : ST_PF_RD;
            ST_PF_RD:   n_state = ST_PF_EX;
            ST_PF_EX: begin
                if (pf_hit) n_state = ST_DG_RD;
                else if (pk_last) n_state = ST_PF_NEW;
                else n_state = ST_PF_RD;
            end
            ST_PF_NEW:  n_state = ST_PT_DONE;
            ST_DG_RD:   n_state = ST_DG_EX;
            ST_DG_EX:   n_state = ST_PT_DONE;
            ST_PT_DONE: begin
                if (!r_half) n_state = ST_PA_SEL;
                else if (r_idx == r_sidx) n_state = ST_O_WAIT;
                else if (last_i) n_state = (r_np != PCW'(r_cnt)) ? ST_O_WAIT : ST_DS_RD;
                else n_state = ST_PA_RD;
            end
            ST_DS_RD:   n_state = ST_DS_EX;
            ST_DS_EX: begin
                if (r_dd != 2'd2) n_state = ST_O_WAIT;
                else if (pk_last) n_state = ST_W0_RD;
                else n_state = ST_DS_RD;
            end
            ST_W0_RD:   n_state = ST_W0_EX;
            ST_W0_EX:   n_state = ST_WS_RD;
            ST_WS_RD:   n_state = ST_WS_EX;
            ST_WS_EX: begin
                if (w_hit && r_found) n_state = ST_O_WAIT;
                else if (last_i) n_state = ST_WC;
                else n_state = ST_WS_RD;
            end
            ST_WC: begin
                if (!r_found) n_state = ST_O_WAIT;
                else if (k_last) n_state = ST_CLOSE;
                else n_state = ST_WS_RD;
            end
            ST_CLOSE:   n_state = close_ok ? ST_X_RD : ST_O_WAIT;
            ST_X_RD:    n_state = ST_X_EX;
            ST_X_EX: begin
                if (!x_skip) n_state = ST_XO;
                else n_state = x_done ? ST_O_RD : ST_X_RD;
            end
            ST_XO:      n_state = ST_XW;
            ST_XW: begin
                if (ors.done) n_state = (r_m == 2'd3) ? ST_X_EV : ST_XO;
            end
            ST_X_EV: begin
                if (x_cross) n_state = ST_O_WAIT;
                else n_state = x_done ? ST_O_RD : ST_X_RD;
            end
            ST_O_RD:    n_state = ST_O_EX;
            ST_O_EX:    n_state = ST_O_WAIT;
            ST_O_WAIT: begin
                if (o_res.ready) n_state = r_out.last_result ? ST_IDLE : ST_O_RD;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Datapath updates and memory writes of each sequencer step.
    always_comb begin
        n_cnt = r_cnt;  n_ovf = r_ovf;  n_i = r_i;  n_j = r_j;  n_k = r_k;
        n_pick_i = r_pick_i;  n_np = r_np;  n_pk = r_pk;  n_idx = r_idx;
        n_sidx = r_sidx;  n_half = r_half;  n_p = r_p;  n_start = r_start;
        n_cur = r_cur;  n_used = r_used;  n_found = r_found;  n_pick = r_pick;
        n_m = r_m;  n_ox = r_ox;  n_out = r_out;  n_ov = r_ov;
        seg_we = 1'b0;  loop_we = 1'b0;  pts_we = 1'b0;  deg_we = 1'b0;
        loop_waddr = r_k;  loop_wdata = r_pick;
        pts_waddr = r_np[PW-1:0];  deg_wdata = 2'd1;
        case (r_state)
            ST_IDLE: begin
                if (acc_in) begin
                    if (r_cnt < CW'(MAX_LINES)) begin
                        seg_we = 1'b1;
                        n_cnt  = r_cnt + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            ST_EVAL: begin
                if (r_ovf) begin
                    n_out = err_result(STS_OVERFLOW);
                    n_ov  = 1'b1;
                end else if (r_cnt < CW'(3)) begin
                    n_out = err_result(STS_TOO_FEW);
                    n_ov  = 1'b1;
                end else begin
                    n_i = '0;
                    n_j = IW'(1);
                end
            end
            ST_DUP_EX: begin
                if (dup_hit) begin
                    n_out = err_result(STS_DUP);
                    n_ov  = 1'b1;
                end else if (x_done) begin
                    n_i    = '0;
                    n_np   = '0;
                    n_half = 1'b0;
                end else if (last_j) begin
                    n_i = r_i + IW'(1);
                    n_j = r_i + IW'(2);
                end else begin
                    n_j = r_j + IW'(1);
                end
            end
            ST_PA_SEL: begin
                n_p  = r_half ? r_sa.e : r_sa.s;
                n_pk = '0;
            end
            ST_PF_EX: begin
                if (pf_hit) n_idx = r_pk;
                else if (!pk_last) n_pk = r_pk + PW'(1);
            end
            ST_PF_NEW: begin
                pts_we = 1'b1;
                deg_we = 1'b1;
                n_idx  = r_np[PW-1:0];
                n_np   = r_np + PCW'(1);
            end
            ST_DG_EX: begin
                deg_we    = 1'b1;
                pts_waddr = r_pk;
                deg_wdata = (r_dd == 2'd3) ? 2'd3 : r_dd + 2'd1;
            end
            ST_PT_DONE: begin
                if (!r_half) begin
                    n_sidx = r_idx;
                    n_half = 1'b1;
                end else if (r_idx == r_sidx) begin
                    n_out = err_result(STS_DEGEN);
                    n_ov  = 1'b1;
                end else begin
                    n_half = 1'b0;
                    if (!last_i) begin
                        n_i = r_i + IW'(1);
                    end else if (r_np != PCW'(r_cnt)) begin
                        n_out = err_result(STS_CONTOUR);
                        n_ov  = 1'b1;
                    end else begin
                        n_pk = '0;
                    end
                end
            end
            ST_DS_EX: begin
                if (r_dd != 2'd2) begin
                    n_out = err_result(STS_BRANCH);
                    n_ov  = 1'b1;
                end else if (pk_last) begin
                    n_i = '0;
                end else begin
                    n_pk = r_pk + PW'(1);
                end
            end
            ST_W0_EX: begin
                loop_we    = 1'b1;
                loop_waddr = '0;
                loop_wdata = r_sa;
                n_start    = r_sa.s;
                n_cur      = r_sa.e;
                n_used     = MAX_LINES'(1);
                n_k        = IW'(1);
                n_found    = 1'b0;
            end
            ST_WS_EX: begin
                if (w_hit && r_found) begin
                    n_out = err_result(STS_AMBIG);
                    n_ov  = 1'b1;
                end else begin
                    if (w_hit) begin
                        // The end matching the cursor takes precedence: flip the edge.
                        n_found    = 1'b1;
                        n_pick_i   = r_i;
                        n_pick.id  = r_sa.id;
                        n_pick.s   = w_me ? r_sa.e : r_sa.s;
                        n_pick.e   = w_me ? r_sa.s : r_sa.e;
                    end
                    if (!last_i) n_i = r_i + IW'(1);
                end
            end
            ST_WC: begin
                if (!r_found) begin
                    n_out = err_result(STS_WALK_GAP);
                    n_ov  = 1'b1;
                end else begin
                    loop_we          = 1'b1;
                    n_used[r_pick_i] = 1'b1;
                    n_cur            = r_pick.e;
                    n_found          = 1'b0;
                    n_i              = '0;
                    if (!k_last) n_k = r_k + IW'(1);
                end
            end
            ST_CLOSE: begin
                if (!close_ok) begin
                    n_out = err_result(STS_OPEN);
                    n_ov  = 1'b1;
                end else begin
                    n_i = '0;
                    n_j = IW'(1);
                end
            end
            ST_X_EX, ST_X_EV: begin
                if (r_state == ST_X_EV && x_cross) begin
                    n_out = err_result(STS_SELF_X);
                    n_ov  = 1'b1;
                end else if (r_state == ST_X_EX && !x_skip) begin
                    n_m = '0;
                end else if (x_done) begin
                    n_i = '0;
                end else if (last_j) begin
                    n_i = r_i + IW'(1);
                    n_j = r_i + IW'(2);
                end else begin
                    n_j = r_j + IW'(1);
                end
            end
            ST_XW: begin
                if (ors.done) begin
                    n_ox[r_m] = ors.o;
                    n_m       = r_m + 2'd1;
                end
            end
            ST_O_EX: begin
                n_out.status      = STS_OK;
                n_out.position    = POS_W'(r_i);
                n_out.edge_id     = r_la.id;
                n_out.vertex_x    = r_la.s.x;
                n_out.vertex_y    = r_la.s.y;
                n_out.last_result = last_i;
                n_ov              = 1'b1;
            end
            ST_O_WAIT: begin
                if (o_res.ready) begin
                    n_ov = 1'b0;
                    if (r_out.last_result) begin
                        n_cnt = '0;
                        n_ovf = 1'b0;
                    end else begin
                        n_i = r_i + IW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptol <= '0;
            r_atol <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_POINT_TOL: r_ptol <= i_cfg_data[PTOL_W-1:0];
                REG_AREA_TOL:  r_atol <= i_cfg_data[ATOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;  r_j <= n_j;  r_k <= n_k;  r_pick_i <= n_pick_i;
        r_np <= n_np;  r_pk <= n_pk;  r_idx <= n_idx;  r_sidx <= n_sidx;
        r_half <= n_half;  r_p <= n_p;  r_start <= n_start;  r_cur <= n_cur;
        r_used <= n_used;  r_found <= n_found;  r_pick <= n_pick;  r_m <= n_m;
        r_ox <= n_ox;  r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (seg_we) seg_mem[r_cnt[IW-1:0]] <= seg_wdata;
        r_sa <= seg_mem[r_i];
        r_sb <= seg_mem[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (loop_we) loop_mem[loop_waddr] <= loop_wdata;
        r_la <= loop_mem[r_i];
        r_lb <= loop_mem[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (pts_we) pts_mem[pts_waddr] <= r_p;
        r_pd <= pts_mem[r_pk];
    end

    always_ff @(posedge i_clk) begin
        if (deg_we) deg_mem[pts_waddr] <= deg_wdata;
        r_dd <= deg_mem[r_pk];
    end

endmodule

// ===== rtl/core/clo_checker.sv =====
`include "assert_macros.svh"

module clo_checker
    import clo_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_in_last,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_result i_out_data
);

    `CLO_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
    `CLO_ASSERT(a_no_overlap, !(i_in_ready && i_out_valid))
    `CLO_ASSERT(a_last_busy, i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
    `CLO_ASSERT(a_err_single, i_out_valid && i_out_data.status != STS_OK |-> i_out_data.last_result && i_out_data.position == '0)
    `CLO_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !i_out_valid)

endmodule

bind closed_loop_orderer clo_checker u_clo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_seg.valid),
    .i_in_ready  (i_seg.ready),
    .i_in_last   (i_seg.data.last_segment),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);
